>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge while out of reset.
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge while out of reset.
`define CHK_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tapq_pkg.sv
// ----------------------------------------------------------------------------
// Two-axis PID mixer package
// Shared widths, register indexes and the handshake type of the serial multiplier.
// ----------------------------------------------------------------------------
package tapq_pkg;

    localparam int ANGLE_W  = 16;
    localparam int GAIN_W   = 24;
    localparam int COEF_W   = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int DRIVE_W  = 16;
    localparam int SMOOTH_W = 32;
    localparam int ACC_W    = 40;
    localparam int ERR_W    = 32;
    localparam int DIGIT_W_DEF = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_SMOOTH_COEF  = 3'd3,
        REG_TARGET_PITCH = 3'd4,
        REG_TARGET_ROLL  = 3'd5
    } cfg_idx_t;

    // Start/finish handshake of the serial multiplier.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mul_ctl_t;

endpackage

>>> rtl/core/tapq_serial_mul.sv
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Signed multiplicand times unsigned multiplier, one digit of the multiplier
// per cycle, accumulated through a shift register.
// ----------------------------------------------------------------------------
module tapq_serial_mul
#(
    parameter int A_W     = 34,
    parameter int B_W     = 24,
    parameter int DIGIT_W = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [A_W-1:0] a,
    input  logic        [B_W-1:0] b,
    output tapq_pkg::mul_ctl_t   ctl,
    output logic signed [A_W+B_W-1:0] p
);
    import tapq_pkg::*;

    localparam int STEPS = (B_W + DIGIT_W - 1) / DIGIT_W;
    localparam int BP_W  = STEPS * DIGIT_W;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int ACC_W2 = A_W + BP_W + 1;

    logic signed [A_W-1:0]    a_reg;
    logic        [BP_W-1:0]   b_reg;
    logic signed [ACC_W2-1:0] acc_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic signed [A_W+DIGIT_W:0] part;
    logic signed [ACC_W2-1:0]    acc_next;

    // Partial product of the top digit, added at the bottom of the left-shifted accumulator.
    always_comb
    begin
        part = a_reg * $signed({1'b0, b_reg[BP_W-1 -: DIGIT_W]});
        acc_next = (acc_reg <<< DIGIT_W)
                 + (ACC_W2'(part) <<< 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands load on start, then one digit shifts out a cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= BP_W'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << DIGIT_W;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign p = acc_reg[A_W+B_W-1:0];

endmodule

>>> rtl/core/two_axis_pid_quad_mixer.sv
// ----------------------------------------------------------------------------
// Two-axis PID quad mixer
// Low-pass filter, PID per axis and four-motor mixing on one serial multiplier.
// ----------------------------------------------------------------------------
// One transfer carries a pitch and a roll angle. Each is smoothed, run through
// a PID and the six terms are mixed into four rounded, saturated drives. All
// eight products go one after another through one multiplier that takes one
// 4-bit digit of its 24-bit operand per cycle. Alpha is carried at 24 bits as
// well, so every product runs through all digits of the 24-bit operand. The two
// filter products come first, then the error step, the six PID products, the
// mixing of the four drives one at a time and the output step. A new input is
// taken only once the output step has gone back to idle, never while an item is
// in work. Mixing waits while the previous result has not yet been transferred.
module two_axis_pid_quad_mixer
#(
    parameter int DIGIT_W = tapq_pkg::DIGIT_W_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tapq_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [tapq_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tapq_pkg::ANGLE_W-1:0]  angle_pitch,
    input  logic signed [tapq_pkg::ANGLE_W-1:0]  angle_roll,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tapq_pkg::DRIVE_W-1:0]  drive_one,
    output logic signed [tapq_pkg::DRIVE_W-1:0]  drive_two,
    output logic signed [tapq_pkg::DRIVE_W-1:0]  drive_three,
    output logic signed [tapq_pkg::DRIVE_W-1:0]  drive_four
);
    import tapq_pkg::*;

    localparam int MA_W = 34;
    localparam int MP_W = MA_W + GAIN_W;
    localparam int SUM_W = 62;

    typedef enum logic [3:0] {
        S_IDLE, S_FILT, S_ERR, S_PROP, S_INTEG, S_DERIV, S_MIX, S_OUT
    } state_t;

    // Configuration registers
    logic [GAIN_W-1:0]         prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [COEF_W-1:0]         smooth_coef_reg;
    logic signed [ANGLE_W-1:0] target_pitch_reg, target_roll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= GAIN_W'(65536);
            integ_gain_reg   <= GAIN_W'(131);
            deriv_gain_reg   <= GAIN_W'(32768);
            smooth_coef_reg  <= COEF_W'(6554);
            target_pitch_reg <= '0;
            target_roll_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                REG_SMOOTH_COEF:  smooth_coef_reg  <= cfg_data[COEF_W-1:0];
                REG_TARGET_PITCH: target_pitch_reg <= cfg_data[ANGLE_W-1:0];
                REG_TARGET_ROLL:  target_roll_reg  <= cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and state
    state_t                    state_reg;
    logic                      axis_reg;
    logic                      launched_reg;
    logic                      out_valid_reg;
    logic signed [SMOOTH_W-1:0] sm_reg [2];
    logic signed [ACC_W-1:0]    acc_reg [2];
    logic signed [ERR_W-1:0]    perr_reg [2];
    logic signed [ERR_W-1:0]    err_reg [2];
    logic signed [ANGLE_W-1:0]  ang_reg [2];
    logic signed [SUM_W-1:0]    pt_reg [2];
    logic signed [SUM_W-1:0]    dt_reg [2];
    logic [1:0]                 mix_reg;
    logic signed [DRIVE_W-1:0]  drv_reg [4];

    // Shared multiplier
    logic                      mul_start;
    logic signed [MA_W-1:0]    mul_a;
    logic        [GAIN_W-1:0]  mul_b;
    mul_ctl_t                  mul_ctl;
    logic signed [MP_W-1:0]    mul_p;

    tapq_serial_mul #(.A_W(MA_W), .B_W(GAIN_W), .DIGIT_W(DIGIT_W)) u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .ctl   (mul_ctl),
        .p     (mul_p)
    );

    // Rounding of a Q.32 product to Q.16, ties away from zero.
    function automatic logic signed [MP_W-16:0] rnd16(input logic signed [MP_W-1:0] v);
        logic signed [MP_W:0] t;
        begin
            t = v[MP_W-1] ? ($signed({v[MP_W-1], v}) + 17'sd32767)
                          : ($signed({v[MP_W-1], v}) + 17'sd32768);
            return t[MP_W:16];
        end
    endfunction

    // Operand selection
    logic ax;
    always_comb
    begin
        ax = axis_reg;
        mul_start = (state_reg == S_FILT || state_reg == S_PROP ||
                     state_reg == S_INTEG || state_reg == S_DERIV) && !launched_reg;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_FILT:
            begin
                mul_a = MA_W'($signed({ang_reg[ax], 8'd0})) - MA_W'(sm_reg[ax]);
                mul_b = GAIN_W'(smooth_coef_reg);
            end
            S_PROP:
            begin
                mul_a = MA_W'(err_reg[ax]);
                mul_b = prop_gain_reg;
            end
            S_INTEG:
            begin
                mul_a = MA_W'(err_reg[ax]);
                mul_b = integ_gain_reg;
            end
            S_DERIV:
            begin
                mul_a = MA_W'(err_reg[ax]) - MA_W'(perr_reg[ax]);
                mul_b = deriv_gain_reg;
            end
            default: ;
        endcase
    end

    // Integral update with saturation.
    logic signed [ACC_W+1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic signed [MP_W-16:0]  rp;
    always_comb
    begin
        rp = rnd16(mul_p);
        acc_sum = (ACC_W+2)'(acc_reg[ax]) + (ACC_W+2)'(rp);
        if (acc_sum > $signed((ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}})))
            acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
        else if (acc_sum < -$signed((ACC_W+2)'({1'b1, {(ACC_W-1){1'b0}}})))
            acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
        else
            acc_sat = acc_sum[ACC_W-1:0];
    end

    // Mixing of one drive per cycle while no earlier result is pending: sign pattern per motor.
    logic signed [SUM_W+3:0] mix_sum;
    logic signed [SUM_W+3:0] ix, iy, px, py, dx, dy;
    logic signed [SUM_W+3:0] mix_rnd;
    logic signed [DRIVE_W-1:0] mix_sat;
    always_comb
    begin
        px = (SUM_W+4)'(pt_reg[0]);
        py = (SUM_W+4)'(pt_reg[1]);
        dx = (SUM_W+4)'(dt_reg[0]);
        dy = (SUM_W+4)'(dt_reg[1]);
        ix = (SUM_W+4)'(acc_reg[0]) <<< 16;
        iy = (SUM_W+4)'(acc_reg[1]) <<< 16;
        unique case (mix_reg)
            2'd0: mix_sum =  px - py - ix + iy - dx + dy;
            2'd1: mix_sum =  px + py + ix + iy + dx + dy;
            2'd2: mix_sum = -px + py - ix + iy - dx - dy;
            default: mix_sum = -px - py + ix + iy + dx - dy;
        endcase
        mix_rnd = mix_sum[SUM_W+3]
                ? ((mix_sum + $signed((SUM_W+4)'(33'h7FFFFFFF))) >>> 32)
                : ((mix_sum + $signed((SUM_W+4)'(33'h80000000))) >>> 32);
        if (mix_rnd > (SUM_W+4)'(32767))
            mix_sat = 16'sh7FFF;
        else if (mix_rnd < -(SUM_W+4)'(32768))
            mix_sat = 16'sh8000;
        else
            mix_sat = mix_rnd[DRIVE_W-1:0];
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mix_reg       <= '0;
            for (int i = 0; i < 2; i++)
            begin
                sm_reg[i]   <= '0;
                acc_reg[i]  <= '0;
                perr_reg[i] <= '0;
                err_reg[i]  <= '0;
                ang_reg[i]  <= '0;
                pt_reg[i]   <= '0;
                dt_reg[i]   <= '0;
            end
            for (int i = 0; i < 4; i++)
                drv_reg[i] <= '0;
        end
        else
        begin
            if (mul_start)
                launched_reg <= 1'b1;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ang_reg[0] <= angle_pitch;
                        ang_reg[1] <= angle_roll;
                        axis_reg   <= 1'b0;
                        state_reg  <= S_FILT;
                    end
                end
                S_FILT:
                begin
                    if (mul_ctl.done)
                    begin
                        sm_reg[ax]   <= sm_reg[ax] + SMOOTH_W'(rp);
                        launched_reg <= 1'b0;
                        axis_reg     <= ~axis_reg;
                        if (ax)
                            state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg[0] <= ERR_W'($signed({target_pitch_reg, 8'd0})) - sm_reg[0];
                    err_reg[1] <= ERR_W'($signed({target_roll_reg, 8'd0})) - sm_reg[1];
                    state_reg  <= S_PROP;
                end
                S_PROP:
                begin
                    if (mul_ctl.done)
                    begin
                        pt_reg[ax]   <= SUM_W'(mul_p);
                        launched_reg <= 1'b0;
                        state_reg    <= S_INTEG;
                    end
                end
                S_INTEG:
                begin
                    if (mul_ctl.done)
                    begin
                        acc_reg[ax]  <= acc_sat;
                        launched_reg <= 1'b0;
                        state_reg    <= S_DERIV;
                    end
                end
                S_DERIV:
                begin
                    if (mul_ctl.done)
                    begin
                        dt_reg[ax]   <= SUM_W'(mul_p);
                        perr_reg[ax] <= err_reg[ax];
                        launched_reg <= 1'b0;
                        axis_reg     <= ~axis_reg;
                        state_reg    <= ax ? S_MIX : S_PROP;
                        mix_reg      <= '0;
                    end
                end
                S_MIX:
                begin
                    if (!out_valid_reg)
                    begin
                        drv_reg[mix_reg] <= mix_sat;
                        mix_reg <= mix_reg + 1'b1;
                        if (mix_reg == 2'd3)
                            state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_one   = drv_reg[0];
    assign drive_two   = drv_reg[1];
    assign drive_three = drv_reg[2];
    assign drive_four  = drv_reg[3];

endmodule

>>> rtl/core/tapq_checker.sv
// ----------------------------------------------------------------------------
// Two-axis PID mixer port checker
// Watches the handshake ports of the top level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tapq_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] drive_one
);
    // A stalled result keeps the value of its first drive.
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(drive_one), "result changed while stalled")
    // A stalled result stays offered.
    `CHK_NEXT(a_out_stay, clk, rst_n, out_valid && !out_ready, out_valid, "result withdrawn")
    // An accepted input is not followed at once by another acceptance.
    `CHK_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "input taken twice")
    // A result never appears the cycle after an input transfer.
    `CHK_NEXT(a_latency, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid, "result too early")
endmodule

bind two_axis_pid_quad_mixer tapq_checker u_tapq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive_one (drive_one)
);
